// ===== rtl/pkdf_pkg.sv =====
// ----------------------------------------------------------------------------
// pkdf_pkg
// Shared types and constants of the per-key press debounce filter.
// ----------------------------------------------------------------------------
package pkdf_pkg;

	// key table size
	localparam int KEY_COUNT = 256;
	localparam int KEY_W     = $clog2(KEY_COUNT);

	// field widths
	localparam int CODE_W = 16;
	localparam int TS_W   = 32;
	localparam int WIN_W  = 16;

	// configuration register indexes
	localparam logic REG_DEBOUNCE = 1'b0;
	localparam logic REG_GRACE    = 1'b1;

	// configuration reset values
	localparam logic [WIN_W-1:0] DEBOUNCE_RESET = WIN_W'(90);
	localparam logic [WIN_W-1:0] GRACE_RESET    = WIN_W'(1000);

	// action codes
	localparam logic [1:0] ACT_RELEASE = 2'd0;
	localparam logic [1:0] ACT_PRESS   = 2'd1;

	// one key table entry
	typedef struct packed {
		logic            held;
		logic [TS_W-1:0] press_time;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// word under evaluation
	typedef struct packed {
		logic            track;
		logic [1:0]      action;
		logic [TS_W-1:0] ts;
	} item_t;

	// outcome of evaluating one word against its table entry
	typedef struct packed {
		logic            fwd;
		logic [TS_W-1:0] elapsed;
		logic            wr_en;
		entry_t          wr_entry;
		logic            set_seen;
	} decide_t;

	// controller states
	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

endpackage

// ===== rtl/per_key_press_debounce_filter.sv =====
// ----------------------------------------------------------------------------
// per_key_press_debounce_filter
// Drops chattering key presses: per key it keeps the last press time and a
// held mark in a RAM, and a seen mark in flip-flops.
//
//   channel | handshake          | payload
//   --------+--------------------+--------------------------------------------
//   in      | in_valid/in_stall  | is_key_event, key_code, action, timestamp_ms
//   out     | out_valid/out_stall| forward, elapsed_ms
//   cfg     | cfg_we             | cfg_index, cfg_data
//
// Each word first reads the key entry from the RAM, then is decided, written
// back and loaded into the output register; the registered RAM read sets that
// order, and one word is in work at a time.
// A finished word waits in the output register while the next is accepted.
// Seen marks clear at reset; the RAM needs no clearing.
// A word held by out_stall keeps the evaluation stage waiting.
// ----------------------------------------------------------------------------
module per_key_press_debounce_filter import pkdf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// configuration
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [WIN_W-1:0]  cfg_data,
	// input words
	input  logic              in_valid,
	output logic              in_stall,
	input  logic              is_key_event,
	input  logic [CODE_W-1:0] key_code,
	input  logic [1:0]        action,
	input  logic [TS_W-1:0]   timestamp_ms,
	// result words
	output logic              out_valid,
	input  logic              out_stall,
	output logic              forward,
	output logic [TS_W-1:0]   elapsed_ms
);

	state_t              state_q;
	logic [WIN_W-1:0]    debounce_q;
	logic [WIN_W-1:0]    grace_q;
	logic [KEY_COUNT-1:0] seen_q;
	item_t               item_q;
	logic [KEY_W-1:0]    addr_q;
	logic                seen_rd_q;
	logic                out_valid_q;
	logic                fwd_q;
	logic [TS_W-1:0]     elapsed_q;
	logic                in_acc;
	logic                commit;
	logic [ENTRY_W-1:0]  rd_data;
	entry_t              rd_entry;
	decide_t             dec;
	logic [KEY_W-1:0]    in_addr;

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign in_addr  = key_code[KEY_W-1:0];
	assign commit   = (state_q == ST_EXEC) && (!out_valid_q || !out_stall);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			grace_q    <= GRACE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data;
				REG_GRACE:    grace_q    <= cfg_data;
				default:      ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_acc) state_q <= ST_EXEC;
				ST_EXEC: if (commit) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// capture of the accepted word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_q.track  <= is_key_event && (key_code < CODE_W'(KEY_COUNT));
			item_q.action <= action;
			item_q.ts     <= timestamp_ms;
			addr_q        <= in_addr;
			seen_rd_q     <= seen_q[in_addr];
		end
	end

	// key entry table
	pkdf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (KEY_COUNT)
	) u_entry_ram (
		.clk   (clk),
		.we    (commit && dec.wr_en),
		.waddr (addr_q),
		.wdata (dec.wr_entry),
		.re    (in_acc),
		.raddr (in_addr),
		.rdata (rd_data)
	);

	assign rd_entry = rd_data;

	// decision logic
	pkdf_decide u_decide (
		.item         (item_q),
		.seen         (seen_rd_q),
		.rd_entry     (rd_entry),
		.debounce_win (debounce_q),
		.grace_win    (grace_q),
		.dec          (dec)
	);

	// seen marks
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (commit && dec.set_seen) begin
			seen_q[addr_q] <= 1'b1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			fwd_q     <= dec.fwd;
			elapsed_q <= dec.elapsed;
		end
	end

	assign out_valid  = out_valid_q;
	assign forward    = fwd_q;
	assign elapsed_ms = elapsed_q;

endmodule

// ===== rtl/pkdf_ram.sv =====
// ----------------------------------------------------------------------------
// pkdf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pkdf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, held when not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/pkdf_decide.sv =====
// ----------------------------------------------------------------------------
// pkdf_decide
// Evaluates one key word against its table entry: elapsed time, drop
// decision and the entry write-back.
// ----------------------------------------------------------------------------
module pkdf_decide import pkdf_pkg::*; (
	input  item_t            item,
	input  logic             seen,
	input  entry_t           rd_entry,
	input  logic [WIN_W-1:0] debounce_win,
	input  logic [WIN_W-1:0] grace_win,
	output decide_t          dec
);

	logic            held;
	logic [TS_W-1:0] elapsed;
	logic            is_press;
	logic            is_release;
	logic            in_grace;
	logic            drop;

	// unseen keys read as never pressed and not held
	assign held    = seen & rd_entry.held;
	assign elapsed = seen ? (item.ts - rd_entry.press_time) : '0;

	assign is_press   = (item.action == ACT_PRESS);
	assign is_release = (item.action == ACT_RELEASE);
	assign in_grace   = (item.ts < {{(TS_W-WIN_W){1'b0}}, grace_win});

	// double press of a released key inside the debounce window, outside grace, nonzero elapsed
	assign drop = is_press && !in_grace && seen && !held &&
		(elapsed != '0) && (elapsed < {{(TS_W-WIN_W){1'b0}}, debounce_win});

	// result and write-back
	always_comb begin
		dec.fwd      = !(item.track && drop);
		dec.elapsed  = item.track ? elapsed : '0;
		dec.wr_en    = 1'b0;
		dec.set_seen = 1'b0;
		dec.wr_entry = rd_entry;
		if (item.track && is_press && !drop) begin
			dec.wr_en               = 1'b1;
			dec.set_seen            = 1'b1;
			dec.wr_entry.held       = 1'b1;
			dec.wr_entry.press_time = item.ts;
		end else if (item.track && is_release) begin
			dec.wr_en         = 1'b1;
			dec.wr_entry.held = 1'b0;
		end
	end

endmodule

// ===== rtl/pkdf_checker.sv =====
// ----------------------------------------------------------------------------
// pkdf_port_checks
// Port-level checks of the per-key press debounce filter, bound to the top.
// ----------------------------------------------------------------------------
module pkdf_port_checks import pkdf_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              is_key_event,
	input logic [CODE_W-1:0] key_code,
	input logic              out_valid,
	input logic              out_stall,
	input logic              forward,
	input logic [TS_W-1:0]   elapsed_ms
);

	// a stalled result word stays offered
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result word withdrawn under stall");

	// a stalled result word keeps its payload
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(forward) && $stable(elapsed_ms))
		else $error("result payload changed under stall");

	// one word in work at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second word accepted while one is in work");

	// untracked words accepted with no result waiting pass with zero elapsed time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !out_valid &&
		(!is_key_event || key_code >= CODE_W'(KEY_COUNT))
		|=> ##1 (out_valid && forward && elapsed_ms == '0))
		else $error("untracked word not passed through");

endmodule

bind per_key_press_debounce_filter pkdf_port_checks u_pkdf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_stall     (in_stall),
	.is_key_event (is_key_event),
	.key_code     (key_code),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.forward      (forward),
	.elapsed_ms   (elapsed_ms)
);
